// File: sv/direction_hue_color_macros.svh
// assertion macros for the direction-to-hue color block
// used by modules that need clk and rst_n in scope; no other dependencies
`ifndef DIRECTION_HUE_COLOR_MACROS_SVH
`define DIRECTION_HUE_COLOR_MACROS_SVH

// condition implies consequence in the same cycle
`define DHC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define DHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dhc_pkg.sv
// shared types, constants and functions for the direction-to-hue color block
// no dependencies
`timescale 1ns / 1ps

package dhc_pkg;

    // cordic configuration
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int IDX_W         = $clog2(TABLE_LEN);

    // datapath widths
    localparam int IN_W  = 16;
    localparam int XY_W  = 20;
    localparam int Z_W   = 34;
    localparam int PH_W  = 16;
    localparam int OUT_W = 13;

    // prep stage, cordic cells, phase stage, color stage
    localparam int PIPE_DEPTH = NUM_STAGES + 3;

    // phase and color constants
    localparam logic [PH_W-1:0]  HALF_TURN_PHASE = 16'd32768;
    localparam logic [PH_W-1:0]  THIRD_TWO       = 16'd21845;
    localparam logic [PH_W-1:0]  THIRD_FOUR      = 16'd43690;
    localparam logic [OUT_W-1:0] FULL_OUT        = 13'd4096;
    localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sh0_4000_0000;
    localparam logic [Z_W-1:0]   ROUND_HALF      = 34'h0_0000_8000;

    // color mode codes
    localparam logic MODE_WHITE = 1'b0;
    localparam logic MODE_HUE   = 1'b1;

    typedef struct packed {
        logic signed [IN_W-1:0] vec_x;
        logic signed [IN_W-1:0] vec_y;
    } vec_beat_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } color_beat_t;

    // payload carried along the cordic chain
    typedef struct packed {
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_data_t;

    // atan(2^-i) with one half-turn = 2^31
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                default: v = 32'h00000000;
            endcase
            return signed'({{(Z_W-32){1'b0}}, v});
        end
    endfunction

    // triangle fold of a phase, rounded to q1.12
    function automatic logic [OUT_W-1:0] fold_out(input logic [PH_W-1:0] q);
        logic [PH_W:0]   qf;
        logic [PH_W+1:0] r;
        begin
            if (q > HALF_TURN_PHASE)
                qf = 17'h10000 - {1'b0, q};
            else
                qf = {1'b0, q};
            r = {1'b0, qf} + 18'd4;
            return r[OUT_W+2:3];
        end
    endfunction

endpackage

// File: sv/direction_hue_color.sv
// Direction-to-hue color block. Takes a signed (x, y) vector and returns an
// rgb color in q1.12 from its angle on a hue wheel, or full white when
// color_mode is 0. A beat is taken on every cycle that start is high; busy
// is never raised, so one vector per clock is sustained. Each result shows
// on color for exactly one cycle with done high, once its beat has passed
// through one input stage, one cordic cell per stage, one phase stage and
// one color stage. The receiver cannot stall the output. Write color_mode
// only while no beat is in flight.
//
// top level, depends on dhc_pkg, dhc_prep, dhc_cell, dhc_color and
// direction_hue_color_macros.svh
`timescale 1ns / 1ps
`include "direction_hue_color_macros.svh"

module direction_hue_color (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dhc_pkg::vec_beat_t   vec,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    output logic                 done,
    output dhc_pkg::color_beat_t color
);
    import dhc_pkg::*;

    logic color_mode_reg;
    logic take;

    logic         chain_valid [0:NUM_STAGES];
    cordic_data_t chain_data  [0:NUM_STAGES];

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_mode_reg <= MODE_HUE;
        else if (cfg_we)
            color_mode_reg <= cfg_data;
    end

    // fully pipelined, never stalls
    assign busy = 1'b0;
    assign take = start && !busy;

    // input stage
    dhc_prep u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .vec   (vec),
        .valid (chain_valid[0]),
        .data  (chain_data[0])
    );

    // chain of cordic cells
    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_cell
        dhc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // phase and color stages
    dhc_color u_color (
        .clk        (clk),
        .rst_n      (rst_n),
        .color_mode (color_mode_reg),
        .in_valid   (chain_valid[NUM_STAGES]),
        .in_data    (chain_data[NUM_STAGES]),
        .done       (done),
        .color      (color)
    );

    // checks
    `DHC_ASSERT_SAME(a_done_has_start, done, $past(take, PIPE_DEPTH), "result without a beat")
    `DHC_ASSERT_SAME(a_start_gets_done, $past(take, PIPE_DEPTH), done, "beat lost in pipeline")
    `DHC_ASSERT_NEXT(a_prep_follows_take, take, chain_valid[0], "input beat not taken")

endmodule

// File: sv/dhc_prep.sv
// front stage: registers the vector, folds the left half-plane, flags zero
// depends on dhc_pkg
`timescale 1ns / 1ps

module dhc_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  dhc_pkg::vec_beat_t vec,
    output logic               valid,
    output dhc_pkg::cordic_data_t data
);
    import dhc_pkg::*;

    logic         valid_reg;
    cordic_data_t data_reg;
    cordic_data_t data_next;

    logic signed [XY_W-1:0] xe;
    logic signed [XY_W-1:0] ye;

    // pre-rotation by a quarter turn for negative x
    always_comb
    begin
        xe = XY_W'(vec.vec_x);
        ye = XY_W'(vec.vec_y);
        data_next.zero = (vec.vec_x == '0) && (vec.vec_y == '0);
        data_next.x    = xe;
        data_next.y    = ye;
        data_next.z    = '0;
        if (xe[XY_W-1])
        begin
            if (!ye[XY_W-1])
            begin
                data_next.x = ye;
                data_next.y = -xe;
                data_next.z = QUARTER_TURN;
            end
            else
            begin
                data_next.x = -ye;
                data_next.y = xe;
                data_next.z = -QUARTER_TURN;
            end
        end
    end

    // beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= take;
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// File: sv/dhc_cell.sv
// one cordic vectoring cell: one micro-rotation, registered
// depends on dhc_pkg
`timescale 1ns / 1ps

module dhc_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dhc_pkg::IDX_W-1:0]  stage_idx,
    input  logic                       in_valid,
    input  dhc_pkg::cordic_data_t      in_data,
    output logic                       out_valid,
    output dhc_pkg::cordic_data_t      out_data
);
    import dhc_pkg::*;

    logic         valid_reg;
    cordic_data_t data_reg;
    cordic_data_t data_next;

    logic signed [XY_W-1:0] sx;
    logic signed [XY_W-1:0] sy;
    logic signed [Z_W-1:0]  ang;

    // rotate toward the x axis
    always_comb
    begin
        sx  = in_data.x >>> stage_idx;
        sy  = in_data.y >>> stage_idx;
        ang = atan_entry(stage_idx);
        data_next.zero = in_data.zero;
        if (!in_data.y[XY_W-1])
        begin
            data_next.x = in_data.x + sy;
            data_next.y = in_data.y - sx;
            data_next.z = in_data.z + ang;
        end
        else
        begin
            data_next.x = in_data.x - sy;
            data_next.y = in_data.y + sx;
            data_next.z = in_data.z - ang;
        end
    end

    // beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: sv/dhc_color.sv
// back end: rounds the angle to a phase, then folds it into rgb, or gives full white in white mode
// depends on dhc_pkg and direction_hue_color_macros.svh
`timescale 1ns / 1ps
`include "direction_hue_color_macros.svh"

module dhc_color (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  color_mode,
    input  logic                  in_valid,
    input  dhc_pkg::cordic_data_t in_data,
    output logic                  done,
    output dhc_pkg::color_beat_t  color
);
    import dhc_pkg::*;

    logic              ph_valid_reg;
    logic [PH_W-1:0]   phase_reg;
    logic [PH_W-1:0]   phase_next;
    logic [Z_W-1:0]    zr;

    logic              done_reg;
    color_beat_t       color_reg;
    color_beat_t       color_next;

    // angle rounded half up, offset by a half-turn
    always_comb
    begin
        zr = unsigned'(in_data.z) + ROUND_HALF;
        if (in_data.zero)
            phase_next = HALF_TURN_PHASE;
        else
            phase_next = zr[31:16] ^ HALF_TURN_PHASE;
    end

    // three folds a third of a turn apart, or full white in white mode
    always_comb
    begin
        if (color_mode == MODE_HUE)
        begin
            color_next.red   = fold_out(phase_reg);
            color_next.green = fold_out(phase_reg + THIRD_TWO);
            color_next.blue  = fold_out(phase_reg + THIRD_FOUR);
        end
        else
        begin
            color_next.red   = FULL_OUT;
            color_next.green = FULL_OUT;
            color_next.blue  = FULL_OUT;
        end
    end

    // beat valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            ph_valid_reg <= in_valid;
            done_reg     <= ph_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        color_reg <= color_next;
    end

    assign done  = done_reg;
    assign color = color_reg;

    // checks
    `DHC_ASSERT_NEXT(a_done_follows_phase, ph_valid_reg, done_reg, "phase beat lost")
    `DHC_ASSERT_SAME(a_white_full, done_reg && (color_mode == MODE_WHITE),
        (color_reg.red == FULL_OUT) && (color_reg.green == FULL_OUT) &&
        (color_reg.blue == FULL_OUT), "white mode not full")
    `DHC_ASSERT_SAME(a_color_range, done_reg,
        (color_reg.red <= FULL_OUT) && (color_reg.green <= FULL_OUT) &&
        (color_reg.blue <= FULL_OUT), "channel above full scale")

endmodule
